[hdl/rtu_dfr_pkg.sv]
// Shared types, codes and the CRC-16 byte update for the RTU request deframer.
// No dependencies; every other file in hdl/ imports this package.

package rtu_dfr_pkg;

   // Input beat kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_READ_CODE    = 2'd0;
   localparam logic [1:0] CSR_INFO_CODE    = 2'd1;
   localparam logic [1:0] CSR_IDLE_TIMEOUT = 2'd2;

   // Configuration reset values
   localparam logic [7:0]  READ_CODE_RST    = 8'd3;
   localparam logic [7:0]  INFO_CODE_RST    = 8'd17;
   localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd200;

   // Modbus CRC-16, reflected form
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Frame sizes in bytes
   localparam logic [3:0] INFO_FRAME_BYTES = 4'd4;
   localparam logic [3:0] CRC_SPAN_BYTES   = 4'd6;
   localparam logic [3:0] READ_FRAME_BYTES = 4'd8;
   localparam logic [3:0] HEADER_BYTES     = 4'd2;

   typedef enum logic [1:0] {
      OUTCOME_READ      = 2'd0,
      OUTCOME_INFO      = 2'd1,
      OUTCOME_CRC_ERROR = 2'd2,
      OUTCOME_UNKNOWN   = 2'd3
   } outcome_type;

   typedef struct packed {
      logic [7:0]  read_code;
      logic [7:0]  info_code;
      logic [15:0] idle_timeout;
   } cfg_type;

   typedef struct packed {
      outcome_type outcome;
      logic [7:0]  unit_address;
      logic [15:0] start_register;
      logic [15:0] register_count;
      logic [15:0] received_crc;
      logic [15:0] computed_crc;
   } result_type;

   // Fold one byte into the CRC, eight shift steps
   function automatic logic [15:0] crc_fold(input logic [15:0] crc_i,
                                            input logic [7:0]  data_i);
      logic [15:0] c;
      c = crc_i ^ {8'h00, data_i};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[hdl/rtu_dfr_csr.sv]
// Configuration registers of the RTU request deframer: command codes and idle timeout.
// Depends on rtu_dfr_pkg.

module rtu_dfr_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata,
   output rtu_dfr_pkg::cfg_type  cfg
);
   import rtu_dfr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; an index past the list is dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_READ_CODE:    cfg_in.read_code    = csr_wdata[7:0];
            CSR_INFO_CODE:    cfg_in.info_code    = csr_wdata[7:0];
            CSR_IDLE_TIMEOUT: cfg_in.idle_timeout = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.read_code    <= READ_CODE_RST;
         cfg_ff.info_code    <= INFO_CODE_RST;
         cfg_ff.idle_timeout <= IDLE_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hdl/rtu_dfr_frame.sv]
// Frame assembly for the RTU request deframer: byte store, running CRC, idle timer
// and the per-frame decision. Depends on rtu_dfr_pkg.

module rtu_dfr_frame (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_fire,
   input  logic                     item_kind,
   input  logic [7:0]               item_byte,
   input  rtu_dfr_pkg::cfg_type     cfg,
   output logic                     result_valid,
   output rtu_dfr_pkg::result_type  result
);
   import rtu_dfr_pkg::*;

   logic [3:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] crc_two_ff, crc_two_in;
   logic [15:0] idle_ff, idle_in;
   logic        armed_ff, armed_in;
   logic [7:0]  store_ff [8];
   logic [7:0]  store_in [8];

   // Byte path, before the frame decision
   logic [3:0]  count_byte;
   logic [15:0] crc_byte;
   logic [15:0] crc_two_byte;

   logic        is_read;
   logic        is_info;
   logic        emit;
   logic [15:0] rx_crc_read;
   logic [15:0] rx_crc_info;
   logic [15:0] limit;
   logic [15:0] idle_inc;
   logic        timeout_hit;
   result_type  res;

   // Store the byte and fold it into the CRC
   always_comb begin
      store_in     = store_ff;
      count_byte   = count_ff;
      crc_byte     = crc_ff;
      crc_two_byte = crc_two_ff;
      if (count_ff < READ_FRAME_BYTES) begin
         store_in[count_ff[2:0]] = item_byte;
         if (count_ff < CRC_SPAN_BYTES) begin
            crc_byte = crc_fold(crc_ff, item_byte);
         end
         count_byte = count_ff + 4'd1;
         if (count_byte == HEADER_BYTES) begin
            crc_two_byte = crc_byte;
         end
      end
   end

   // Decide on the frame once the command byte can be judged
   always_comb begin
      is_read     = (store_in[1] == cfg.read_code);
      is_info     = (store_in[1] == cfg.info_code);
      rx_crc_read = {store_in[7], store_in[6]};
      rx_crc_info = {store_in[3], store_in[2]};
      emit        = (count_byte >= INFO_FRAME_BYTES) &&
                    (!is_read || (count_byte == READ_FRAME_BYTES));

      res                = '0;
      res.unit_address   = store_in[0];
      if (is_read) begin
         res.received_crc = rx_crc_read;
         res.computed_crc = crc_byte;
         if (rx_crc_read != crc_byte) begin
            res.outcome = OUTCOME_CRC_ERROR;
         end else begin
            res.outcome        = OUTCOME_READ;
            res.start_register = {store_in[2], store_in[3]};
            res.register_count = {store_in[4], store_in[5]};
         end
      end else if (is_info) begin
         res.received_crc = rx_crc_info;
         res.computed_crc = crc_two_byte;
         res.outcome      = (rx_crc_info != crc_two_byte) ? OUTCOME_CRC_ERROR
                                                          : OUTCOME_INFO;
      end else begin
         res.outcome = OUTCOME_UNKNOWN;
      end
   end

   // Idle timer: saturating count against the limit, zero acts as one
   always_comb begin
      limit       = (cfg.idle_timeout == 16'd0) ? 16'd1 : cfg.idle_timeout;
      idle_inc    = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
      timeout_hit = (idle_inc >= limit);
   end

   // Next frame state
   always_comb begin
      count_in   = count_ff;
      crc_in     = crc_ff;
      crc_two_in = crc_two_ff;
      idle_in    = idle_ff;
      armed_in   = armed_ff;
      if (item_fire) begin
         if (item_kind == KIND_BYTE) begin
            if (emit) begin
               count_in   = 4'd0;
               crc_in     = CRC_INIT;
               crc_two_in = CRC_INIT;
               idle_in    = 16'd0;
               armed_in   = 1'b0;
            end else begin
               count_in   = count_byte;
               crc_in     = crc_byte;
               crc_two_in = crc_two_byte;
               idle_in    = 16'd0;
               armed_in   = 1'b1;
            end
         end else if (armed_ff) begin
            if (timeout_hit) begin
               count_in   = 4'd0;
               crc_in     = CRC_INIT;
               crc_two_in = CRC_INIT;
               idle_in    = 16'd0;
               armed_in   = 1'b0;
            end else begin
               idle_in = idle_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= 4'd0;
         crc_ff     <= CRC_INIT;
         crc_two_ff <= CRC_INIT;
         idle_ff    <= 16'd0;
         armed_ff   <= 1'b0;
      end else begin
         count_ff   <= count_in;
         crc_ff     <= crc_in;
         crc_two_ff <= crc_two_in;
         idle_ff    <= idle_in;
         armed_ff   <= armed_in;
      end
   end

   // Frame bytes carry no reset; only bytes of the current frame are read
   always_ff @(posedge clock) begin
      if (item_fire && (item_kind == KIND_BYTE)) begin
         store_ff <= store_in;
      end
   end

   assign result_valid = item_fire && (item_kind == KIND_BYTE) && emit;
   assign result       = res;

endmodule

[hdl/rtu_request_deframer_crc16.sv]
// Top level of the RTU request deframer: input register, frame logic, result register.
// Depends on rtu_dfr_pkg, rtu_dfr_csr and rtu_dfr_frame.
//
//   channel | direction | handshake          | beat
//   req_    | in        | req_valid/req_stall | kind, rx_byte
//   rsp_    | out       | rsp_valid/rsp_stall | outcome, address, registers, CRCs
//   csr_    | in        | csr_write_en        | csr_index, csr_wdata
//
// One beat per cycle sustained while the result is not stalled; an accepted byte passes
// through the input register, then the frame logic with its byte-wide CRC update, into the
// result register. Reset is synchronous and clears frame state and configuration.
// A stalled result holds the frame logic; the input register still takes one beat.

module rtu_request_deframer_crc16 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_outcome,
   output logic [7:0]  rsp_unit_address,
   output logic [15:0] rsp_start_register,
   output logic [15:0] rsp_register_count,
   output logic [15:0] rsp_received_crc,
   output logic [15:0] rsp_computed_crc,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import rtu_dfr_pkg::*;

   cfg_type    cfg;
   logic       in_vld_ff, in_vld_in;
   logic       in_kind_ff;
   logic [7:0] in_byte_ff;
   logic       out_vld_ff, out_vld_in;
   result_type out_ff;
   result_type frame_result;
   logic       frame_result_valid;
   logic       req_fire;
   logic       advance;

   rtu_dfr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   rtu_dfr_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .item_fire    (advance),
      .item_kind    (in_kind_ff),
      .item_byte    (in_byte_ff),
      .cfg          (cfg),
      .result_valid (frame_result_valid),
      .result       (frame_result)
   );

   // Advance the held beat when the result register is free or being emptied
   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_fire) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      if (advance) begin
         out_vld_in = frame_result_valid;
      end else begin
         out_vld_in = out_vld_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Capture the input beat
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff <= req_kind;
         in_byte_ff <= req_rx_byte;
      end
   end

   // Load the result register only with a real result
   always_ff @(posedge clock) begin
      if (advance && frame_result_valid) begin
         out_ff <= frame_result;
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_outcome        = out_ff.outcome;
   assign rsp_unit_address   = out_ff.unit_address;
   assign rsp_start_register = out_ff.start_register;
   assign rsp_register_count = out_ff.register_count;
   assign rsp_received_crc   = out_ff.received_crc;
   assign rsp_computed_crc   = out_ff.computed_crc;

   // A stalled result is never overwritten by the frame logic
   assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && rsp_stall) |-> !advance)
      else $error("frame logic advanced over a stalled result");

   // The input side stalls only while a beat is held
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff)
      else $error("input stalled with an empty input register");

   // A good read carries matching CRCs
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_outcome == OUTCOME_READ)) |->
         (rsp_received_crc == rsp_computed_crc))
      else $error("read result with mismatching CRC");

   // An unknown command reports no CRCs and no register fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_outcome == OUTCOME_UNKNOWN)) |->
         ((rsp_received_crc == 16'd0) && (rsp_computed_crc == 16'd0) &&
          (rsp_start_register == 16'd0) && (rsp_register_count == 16'd0)))
      else $error("unknown command result carries nonzero fields");

endmodule
